// ===== src/indexed_ring_deque_defines.svh =====
// Assertion macros for the indexed ring deque.
// Needs signals named clk and rst_n in the including module's scope.
`ifndef INDEXED_RING_DEQUE_DEFINES_SVH
`define INDEXED_RING_DEQUE_DEFINES_SVH
`ifndef SYNTHESIS
`define IRDQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define IRDQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define IRDQ_ASSERT(lbl, cond)
`define IRDQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/irdq_pkg.sv =====
// Shared types and codes for the indexed ring deque.
// No dependencies.
package irdq_pkg;

  localparam int IDX_W = 13;

  typedef enum logic [2:0] {
    FN_GET    = 3'd0,
    FN_PUT    = 3'd1,
    FN_INSERT = 3'd2,
    FN_REMOVE = 3'd3,
    FN_ROTATE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT,
    CMD_INS_FRONT,
    CMD_INS,
    CMD_REM
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   sel;
    logic [IDX_W-1:0]   origin;
    logic [IDX_W-1:0]   n;
  } cell_cmd_t;

endpackage

// ===== src/indexed_ring_deque.sv =====
// Indexed ring deque: a ring of DEPTH word cells with a movable origin.
// A request is held in the request register, then the execute cycle over the cell row
// writes the result register; a new request is taken only once the held one has executed.
// Insert and remove shift all affected cells in the single execute cycle.
// Reset (synchronous, rst_n low) clears count, origin and handshake state;
// cell contents stay undefined until written and are never read before that.
module indexed_ring_deque #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_func,
  input  logic [7:0]                   in_index,
  input  logic signed [9:0]            in_position,
  input  logic signed [9:0]            in_shift,
  input  logic [WORD_BITS-1:0]         in_data_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [WORD_BITS-1:0]         out_data_out,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_count
);

`include "indexed_ring_deque_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int SW = irdq_pkg::IDX_W + 1;
  localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic signed [SW-1:0] ONE_S   = SW'(1);

  // request register
  logic                      req_valid_r, req_valid_nxt;
  logic [2:0]                req_func_r;
  logic [7:0]                req_idx_r;
  logic signed [9:0]         req_pos_r;
  logic signed [9:0]         req_sh_r;
  logic [WORD_BITS-1:0]      req_data_r;

  // ring state
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             origin_r, origin_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]      out_data_r, out_data_nxt;
  irdq_pkg::status_t         out_status_r, out_status_nxt;
  logic [CW-1:0]             out_count_r;

  logic                      in_fire, exec;
  irdq_pkg::cell_cmd_t       cmd;
  irdq_pkg::cmd_kind_t       kind;
  logic [irdq_pkg::IDX_W-1:0] sel;

  logic [WORD_BITS-1:0]      cell_word [DEPTH];
  logic [WORD_BITS-1:0]      cell_rd   [DEPTH];
  logic [WORD_BITS-1:0]      rd_word;

  logic signed [SW-1:0]      n_s, idx_s, pos_s, sh_s, at_s, k_s, org_s, sum_s;

  // hold one request; the result register parts us from the output side
  assign in_stall = req_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign exec     = req_valid_r && !(out_valid_r && out_stall);

  assign req_valid_nxt = in_fire || (req_valid_r && !exec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      origin_r    <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r  <= count_nxt;
        origin_r <= origin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func_r <= in_func;
      req_idx_r  <= in_index;
      req_pos_r  <= in_position;
      req_sh_r   <= in_shift;
      req_data_r <= in_data_in;
    end
    if (exec) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid_nxt = exec || (out_valid_r && out_stall);

  // gather the word of the selected cell
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) rd_word = rd_word | cell_rd[i];
  end

  // decode the request against count and origin
  always_comb begin
    n_s    = SW'(count_r);
    idx_s  = SW'(req_idx_r);
    pos_s  = SW'(req_pos_r);
    sh_s   = SW'(req_sh_r);
    org_s  = SW'(origin_r);
    at_s   = (pos_s <= 0) ? (pos_s + n_s) : (pos_s - ONE_S);
    k_s    = (sh_s >= 0) ? ((sh_s == n_s) ? '0 : sh_s) : (sh_s + n_s);
    sum_s  = org_s + k_s;
    if (sum_s >= DEPTH_S) sum_s = sum_s - DEPTH_S;

    kind           = irdq_pkg::CMD_NONE;
    sel            = irdq_pkg::IDX_W'(req_idx_r);
    count_nxt      = count_r;
    origin_nxt     = origin_r;
    out_data_nxt   = '0;
    out_status_nxt = irdq_pkg::ST_OK;

    case (req_func_r)
      irdq_pkg::FN_GET, irdq_pkg::FN_PUT: begin
        if (idx_s >= n_s) begin
          out_status_nxt = irdq_pkg::ST_RANGE;
        end else begin
          out_data_nxt = rd_word;
          if (req_func_r == irdq_pkg::FN_PUT) kind = irdq_pkg::CMD_PUT;
        end
      end
      irdq_pkg::FN_INSERT: begin
        if (pos_s < -n_s || pos_s > n_s + ONE_S) begin
          out_status_nxt = irdq_pkg::ST_RANGE;
        end else if (n_s >= DEPTH_S) begin
          out_status_nxt = irdq_pkg::ST_FULL;
        end else begin
          sel = irdq_pkg::IDX_W'(at_s);
          if (at_s == 0) begin
            // grow at the front: step the origin back one slot
            kind       = irdq_pkg::CMD_INS_FRONT;
            origin_nxt = (origin_r == '0) ? AW'(DEPTH - 1) : (origin_r - 1'b1);
          end else begin
            kind = irdq_pkg::CMD_INS;
          end
          count_nxt    = count_r + 1'b1;
          out_data_nxt = req_data_r;
        end
      end
      irdq_pkg::FN_REMOVE: begin
        if (n_s == 0) begin
          out_status_nxt = irdq_pkg::ST_EMPTY;
        end else if (idx_s >= n_s) begin
          out_status_nxt = irdq_pkg::ST_RANGE;
        end else begin
          out_data_nxt = rd_word;
          if (req_idx_r == '0) begin
            origin_nxt = (origin_r == AW'(DEPTH - 1)) ? '0 : (origin_r + 1'b1);
          end else begin
            kind = irdq_pkg::CMD_REM;
          end
          count_nxt = count_r - 1'b1;
          // an emptied ring restarts at slot zero
          if (count_r == CW'(1)) origin_nxt = '0;
        end
      end
      irdq_pkg::FN_ROTATE: begin
        if (n_s == 0) begin
          out_status_nxt = irdq_pkg::ST_OK;
        end else if (sh_s < -n_s || sh_s > n_s) begin
          out_status_nxt = irdq_pkg::ST_RANGE;
        end else begin
          origin_nxt = AW'(sum_s);
        end
      end
      default: out_status_nxt = irdq_pkg::ST_RANGE;
    endcase

    // drop any cell write when the execute cycle does not fire
    cmd.kind   = exec ? kind : irdq_pkg::CMD_NONE;
    cmd.sel    = sel;
    cmd.origin = irdq_pkg::IDX_W'(origin_r);
    cmd.n      = irdq_pkg::IDX_W'(count_r);
  end

  // row of cells, closed into a ring
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    irdq_cell #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .SLOT      (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .data_in   (req_data_r),
      .prev_word (cell_word[(g + DEPTH - 1) % DEPTH]),
      .next_word (cell_word[(g + 1) % DEPTH]),
      .word      (cell_word[g]),
      .rd_word   (cell_rd[g])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

  `IRDQ_ASSERT(a_count_bound, count_r <= CW'(DEPTH))
  `IRDQ_ASSERT(a_empty_origin, (count_r != '0) || (origin_r == '0))
  `IRDQ_ASSERT_NEXT(a_exec_result, exec, out_valid_r)
  `IRDQ_ASSERT(a_err_zero, !out_valid_r || out_status_r == irdq_pkg::ST_OK || out_data_r == '0)

endmodule

// ===== src/irdq_cell.sv =====
// One storage cell of the ring: holds the word of one physical slot.
// Depends on irdq_pkg for the broadcast command.
module irdq_cell #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32,
  parameter int SLOT      = 0
) (
  input  logic                   clk,
  input  irdq_pkg::cell_cmd_t    cmd,
  input  logic [WORD_BITS-1:0]   data_in,
  input  logic [WORD_BITS-1:0]   prev_word,
  input  logic [WORD_BITS-1:0]   next_word,
  output logic [WORD_BITS-1:0]   word,
  output logic [WORD_BITS-1:0]   rd_word
);

  localparam logic [irdq_pkg::IDX_W-1:0] SLOT_V  = irdq_pkg::IDX_W'(SLOT);
  localparam logic [irdq_pkg::IDX_W-1:0] DEPTH_V = irdq_pkg::IDX_W'(DEPTH);

  logic [WORD_BITS-1:0]          word_r, word_nxt;
  logic [irdq_pkg::IDX_W-1:0]    li;
  logic                          hit;

  // logical index of this slot relative to the origin
  assign li  = (SLOT_V >= cmd.origin) ? (SLOT_V - cmd.origin)
                                      : (SLOT_V + DEPTH_V - cmd.origin);
  assign hit = (li == cmd.sel);

  always_comb begin
    word_nxt = word_r;
    case (cmd.kind)
      irdq_pkg::CMD_PUT: begin
        if (hit) word_nxt = data_in;
      end
      irdq_pkg::CMD_INS_FRONT: begin
        if (li == DEPTH_V - 1'b1) word_nxt = data_in;
      end
      irdq_pkg::CMD_INS: begin
        if (hit) word_nxt = data_in;
        else if (li > cmd.sel && li <= cmd.n) word_nxt = prev_word;
      end
      irdq_pkg::CMD_REM: begin
        if (li >= cmd.sel && (li + 1'b1) < cmd.n) word_nxt = next_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = hit ? word_r : '0;

endmodule

// ===== tb/sv/indexed_ring_deque_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the indexed ring deque: directed table, then random traffic.
// Depends on irdq_pkg and the indexed_ring_deque RTL; no files or arguments are read.
module indexed_ring_deque_test;

  localparam int RING_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  // Reserved function codes; the block must flag them as out of range.
  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  typedef struct {
    logic [31:0]       data;
    irdq_pkg::status_t status;
    int                count;
  } deque_reply_t;

  // One row of the directed table; typed rows carry their own reply.
  typedef struct {
    logic [2:0]   fn;
    int           idx;
    int           pos;
    int           sh;
    logic [31:0]  word;
    bit           typed;
    deque_reply_t reply;
  } deque_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_func;
  logic [7:0]        in_index;
  logic signed [9:0] in_position;
  logic signed [9:0] in_shift;
  logic [31:0]       in_data_in;
  logic              out_valid;
  logic              out_stall;
  logic [31:0]       out_data_out;
  logic [1:0]        out_status;
  logic [8:0]        out_count;

  indexed_ring_deque u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_index     (in_index),
    .in_position  (in_position),
    .in_shift     (in_shift),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_count    (out_count)
  );

  // Shadow copy of the deque: slot store, live element count and origin.
  logic [31:0]  shadow_ring [RING_DEPTH];
  int           live_count;
  int           ring_origin;
  deque_reply_t pending_replies [$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  bit  hold_taken;
  bit  failed;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int slot_of(int logical);
    return (ring_origin + logical) % RING_DEPTH;
  endfunction

  // Apply one operation to the shadow deque and return the reply it produces.
  function automatic deque_reply_t apply_op(logic [2:0] fn, logic [7:0] idx,
                                            logic signed [9:0] pos,
                                            logic signed [9:0] sh, logic [31:0] word);
    deque_reply_t r;
    int n;
    int at;
    int k;
    int p;
    int s;
    n = live_count;
    p = pos;
    s = sh;
    r.data = '0;
    r.status = irdq_pkg::ST_OK;
    case (fn)
      irdq_pkg::FN_GET, irdq_pkg::FN_PUT: begin
        if (int'(idx) >= n) begin
          r.status = irdq_pkg::ST_RANGE;
        end else begin
          r.data = shadow_ring[slot_of(idx)];
          if (fn == irdq_pkg::FN_PUT) shadow_ring[slot_of(idx)] = word;
        end
      end
      irdq_pkg::FN_INSERT: begin
        if (p < -n || p > n + 1) begin
          r.status = irdq_pkg::ST_RANGE;
        end else if (n >= RING_DEPTH) begin
          r.status = irdq_pkg::ST_FULL;
        end else begin
          at = (p <= 0) ? p + n : p - 1;
          // Front insert just pulls the origin back; others shift the tail up.
          if (at == 0) begin
            ring_origin = (ring_origin + RING_DEPTH - 1) % RING_DEPTH;
          end else begin
            for (int i = n; i > at; i--) shadow_ring[slot_of(i)] = shadow_ring[slot_of(i - 1)];
          end
          shadow_ring[slot_of(at)] = word;
          live_count++;
          r.data = word;
        end
      end
      irdq_pkg::FN_REMOVE: begin
        if (n == 0) begin
          r.status = irdq_pkg::ST_EMPTY;
        end else if (int'(idx) >= n) begin
          r.status = irdq_pkg::ST_RANGE;
        end else begin
          r.data = shadow_ring[slot_of(idx)];
          if (idx == 0) begin
            ring_origin = slot_of(1);
          end else begin
            for (int i = idx; i + 1 < n; i++) shadow_ring[slot_of(i)] = shadow_ring[slot_of(i + 1)];
          end
          live_count--;
          if (live_count == 0) ring_origin = 0;
        end
      end
      irdq_pkg::FN_ROTATE: begin
        // Empty ring: nothing to rotate, status stays ok.
        if (n != 0) begin
          if (s < -n || s > n) begin
            r.status = irdq_pkg::ST_RANGE;
          end else begin
            k = (s >= 0) ? s % n : s + n;
            ring_origin = slot_of(k);
          end
        end
      end
      default: r.status = irdq_pkg::ST_RANGE;
    endcase
    r.count = live_count;
    return r;
  endfunction

  // Offer one transaction; hold it until the block takes it, then predict.
  task automatic send_op(logic [2:0] fn, logic [7:0] idx, logic [9:0] pos, logic [9:0] sh,
                         logic [31:0] word, bit typed, deque_reply_t typed_reply);
    deque_reply_t r;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_index    <= idx;
    in_position <= pos;
    in_shift    <= sh;
    in_data_in  <= word;
    do @(posedge clk); while (in_stall);
    r = apply_op(fn, idx, pos, sh, word);
    pending_replies.push_back(typed ? typed_reply : r);
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    int hold_left;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Check every reply the block hands over against the oldest prediction.
  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply data=%h status=%0d count=%0d",
                 $time, out_data_out, out_status, out_count);
        failed = 1'b1;
      end else begin
        want = pending_replies.pop_front();
        if (out_data_out !== want.data) begin
          $display("%0t: data mismatch expected %h actual %h", $time, want.data, out_data_out);
          failed = 1'b1;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want.status, out_status);
          failed = 1'b1;
        end
        if (out_count !== 9'(want.count)) begin
          $display("%0t: count mismatch expected %0d actual %0d", $time, want.count, out_count);
          failed = 1'b1;
        end
      end
    end
  end

  deque_row_t directed_rows [] = '{
    '{irdq_pkg::FN_GET,    0,    0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 0}},
    '{irdq_pkg::FN_REMOVE, 0,    0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_EMPTY, 0}},
    '{irdq_pkg::FN_ROTATE, 0,    0, 5, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{FN_RSVD5,            0,    0, 0, 32'h1,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 0}},
    '{FN_RSVD7,            0,    0, 0, 32'h1,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 0}},
    '{irdq_pkg::FN_INSERT, 0,    2, 0, 32'h1,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 0}},
    '{irdq_pkg::FN_INSERT, 0,    1, 0, 32'hFFFFFFFF, 1'b1,
      '{32'hFFFFFFFF, irdq_pkg::ST_OK,    1}},
    '{irdq_pkg::FN_INSERT, 0,    0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_OK,    2}},
    '{irdq_pkg::FN_INSERT, 0,   -2, 0, 32'hA5A5A5A5, 1'b1,
      '{32'hA5A5A5A5, irdq_pkg::ST_OK,    3}},
    '{irdq_pkg::FN_INSERT, 0,    4, 0, 32'h12345678, 1'b1,
      '{32'h12345678, irdq_pkg::ST_OK,    4}},
    '{irdq_pkg::FN_INSERT, 0,    2, 0, 32'h5A5A5A5A, 1'b1,
      '{32'h5A5A5A5A, irdq_pkg::ST_OK,    5}},
    '{irdq_pkg::FN_INSERT, 0,   -6, 0, 32'h1,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 5}},
    '{irdq_pkg::FN_INSERT, 0, -512, 0, 32'h1,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 5}},
    '{irdq_pkg::FN_GET,    255,  0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 5}},
    '{irdq_pkg::FN_PUT,    2,    0, 0, 32'hDEADBEEF, 1'b0,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{irdq_pkg::FN_GET,    4,    0, 0, 32'h0,        1'b0,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{irdq_pkg::FN_ROTATE, 0,    0, 2, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_OK,    5}},
    '{irdq_pkg::FN_ROTATE, 0,    0, -5, 32'h0,       1'b1,
      '{32'h0,        irdq_pkg::ST_OK,    5}},
    '{irdq_pkg::FN_ROTATE, 0,    0, 6, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 5}},
    '{irdq_pkg::FN_ROTATE, 0,    0, -1, 32'h0,       1'b1,
      '{32'h0,        irdq_pkg::ST_OK,    5}},
    '{irdq_pkg::FN_GET,    0,    0, 0, 32'h0,        1'b0,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{irdq_pkg::FN_REMOVE, 4,    0, 0, 32'h0,        1'b0,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{irdq_pkg::FN_REMOVE, 0,    0, 0, 32'h0,        1'b0,
      '{32'h0,        irdq_pkg::ST_OK,    0}},
    '{irdq_pkg::FN_REMOVE, 9,    0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 3}},
    '{FN_RSVD6,            0,    0, 0, 32'h0,        1'b1,
      '{32'h0,        irdq_pkg::ST_RANGE, 3}}
  };

  // Stimulus: reset, directed table, then three random phases with shifting idle mix.
  initial begin
    deque_reply_t none;
    logic [2:0]   fn;
    logic [7:0]   idx;
    logic [9:0]   pos;
    logic [9:0]   sh;
    int           pick;
    int           n;
    int           phase_items [3];
    int           drain_wait;
    phase_items = '{200, 330, 220};
    none = '{32'h0, irdq_pkg::ST_OK, 0};
    failed = 1'b0;
    cycle_count = 0;
    hold_req = 1'b0;
    live_count = 0;
    ring_origin = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 78;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = irdq_pkg::FN_GET;
    in_index = '0;
    in_position = '0;
    in_shift = '0;
    in_data_in = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_op(directed_rows[i].fn, 8'(directed_rows[i].idx), 10'(directed_rows[i].pos),
              10'(directed_rows[i].sh), directed_rows[i].word, directed_rows[i].typed,
              directed_rows[i].reply);

    for (int phase = 0; phase < 3; phase++) begin
      // Swap the idle mix per phase; the last phase runs flat out.
      tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 78 : 0;
      rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 15 : 0;
      for (int it = 0; it < phase_items[phase]; it++) begin
        // Ask the receiver to hold off while the sender keeps pushing.
        if (phase == 0 && it == 60) hold_req = 1'b1;
        n = live_count;
        pick = $urandom_range(99);
        // Phase 1 drives the deque to full; phase 2 drains it again.
        if (phase == 1 && n < RING_DEPTH)
          fn = (pick < 88) ? irdq_pkg::FN_INSERT : 3'($urandom_range(4));
        else if (phase == 2)
          fn = (pick < 45) ? irdq_pkg::FN_REMOVE : (pick < 62) ? irdq_pkg::FN_INSERT
             : (pick < 64) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        else fn = (pick < 3) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        // Mostly legal arguments, with a tail of arbitrary bit patterns.
        if (n > 0 && $urandom_range(9) < 8) idx = 8'($urandom_range(n - 1));
        else idx = 8'($urandom_range(255));
        if ($urandom_range(9) < 8) pos = 10'($urandom_range(2 * n + 1) - n);
        else pos = 10'($urandom_range(1023));
        if ($urandom_range(9) < 8) sh = 10'($urandom_range(2 * n) - n);
        else sh = 10'($urandom_range(1023));
        send_op(fn, idx, pos, sh, $urandom(), 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    drain_wait = 0;
    while (drain_wait < 20) begin
      @(posedge clk);
      drain_wait++;
    end
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
